// ----- sv/fsr_pkg.sv -----
// Shared types and constants for the frame sample receiver.
package fsr_pkg;

    localparam int LEVEL_W        = 10;
    localparam int INDEX_W        = 6;
    localparam int WORD_W         = 32;
    localparam int CODE_W         = 2;
    localparam int BITS_PER_FRAME = 34;

    localparam logic [INDEX_W-1:0] START_INDEX = '0;
    localparam logic [INDEX_W-1:0] STOP_INDEX  = INDEX_W'(BITS_PER_FRAME - 1);

    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 10'd465;

    localparam logic [CODE_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] ERR_START  = 2'd1;
    localparam logic [CODE_W-1:0] ERR_STOP   = 2'd2;
    localparam logic [CODE_W-1:0] ERR_PARITY = 2'd3;

    localparam logic [2:0] MASTER_MAX_TYPE = 3'd3;

    // One sliced line bit waiting in the input register.
    typedef struct packed {
        logic line_bit;
        logic restart;
    } fsr_bit_t;

    // Finished frame handed to the output register.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CODE_W-1:0] code;
    } fsr_result_t;

endpackage

// ----- sv/fsr_input_stage.sv -----
// Input register: slices each accepted sample against the threshold.
module fsr_input_stage #(
    parameter int CMP_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [fsr_pkg::LEVEL_W-1:0] line_sample,
    input  logic                        frame_start,
    input  logic [fsr_pkg::LEVEL_W-1:0] level_threshold,
    input  logic                        advance,
    output logic                        bit_valid,
    output fsr_pkg::fsr_bit_t           bit_data
);

    logic              valid_reg;
    logic              valid_next;
    fsr_pkg::fsr_bit_t data_reg;
    logic              accept;

    assign in_ready = !valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // strictly greater counts as a one
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg.line_bit <= (line_sample[CMP_BITS-1:0] > level_threshold[CMP_BITS-1:0]);
            data_reg.restart  <= frame_start;
        end
    end

    assign bit_valid = valid_reg;
    assign bit_data  = data_reg;

endmodule

// ----- sv/fsr_frame_core.sv -----
// Frame assembly: bit counter, shift word, parity and framing checks.
module fsr_frame_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        bit_valid,
    input  fsr_pkg::fsr_bit_t           bit_data,
    input  logic                        out_free,
    output logic                        advance,
    output logic                        result_valid,
    output fsr_pkg::fsr_result_t        result,
    output logic [fsr_pkg::INDEX_W-1:0] index_now
);

    logic [fsr_pkg::INDEX_W-1:0] index_reg, index_next, index_eff;
    logic [fsr_pkg::WORD_W-1:0]  shift_reg, shift_next, shift_eff;
    logic                        parity_reg, parity_next;
    logic [fsr_pkg::CODE_W-1:0]  ferr_reg, ferr_next, ferr_eff;
    logic                        at_stop;

    always_comb
    begin
        // a restart drops the partial frame before this bit is used
        index_eff = bit_data.restart ? '0 : index_reg;
        shift_eff = bit_data.restart ? '0 : shift_reg;
        ferr_eff  = bit_data.restart ? fsr_pkg::ERR_NONE : ferr_reg;
        parity_next = (bit_data.restart ? 1'b0 : parity_reg) ^ bit_data.line_bit;
        at_stop   = (index_eff >= fsr_pkg::STOP_INDEX);

        ferr_next  = ferr_eff;
        shift_next = shift_eff;
        if (index_eff == fsr_pkg::START_INDEX)
        begin
            if (!bit_data.line_bit)
            begin
                ferr_next = fsr_pkg::ERR_START;
            end
        end
        else if (at_stop)
        begin
            if (!bit_data.line_bit)
            begin
                ferr_next = fsr_pkg::ERR_STOP;
            end
        end
        else
        begin
            shift_next = {shift_eff[fsr_pkg::WORD_W-2:0], bit_data.line_bit};
        end
        index_next = index_eff + 1'b1;

        // framing errors win; parity only on a well-framed word
        if (ferr_next != fsr_pkg::ERR_NONE)
        begin
            result.code = ferr_next;
        end
        else if (parity_next)
        begin
            result.code = fsr_pkg::ERR_PARITY;
        end
        else
        begin
            result.code = fsr_pkg::ERR_NONE;
        end
        result.word = (result.code == fsr_pkg::ERR_NONE) ? shift_eff : '0;
    end

    assign advance      = bit_valid && (!at_stop || out_free);
    assign result_valid = advance && at_stop;
    assign index_now    = index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg  <= '0;
            shift_reg  <= '0;
            parity_reg <= 1'b0;
            ferr_reg   <= fsr_pkg::ERR_NONE;
        end
        else if (advance)
        begin
            if (at_stop)
            begin
                index_reg  <= '0;
                shift_reg  <= '0;
                parity_reg <= 1'b0;
                ferr_reg   <= fsr_pkg::ERR_NONE;
            end
            else
            begin
                index_reg  <= index_next;
                shift_reg  <= shift_next;
                parity_reg <= parity_next;
                ferr_reg   <= ferr_next;
            end
        end
    end

endmodule

// ----- sv/frame_sample_receiver.sv -----
// Top level of the frame sample receiver.
//
// One line sample per bit time enters on the s_axis channel; its tuser bit
// restarts frame collection with this sample as the start bit. A sample
// above level_threshold is a one. After 34 bits (start, 32 data, stop)
// one transaction leaves on m_axis with the frame word, its decoded fields
// and the error code in tuser; every other sample produces no output.
// level_threshold is written through cfg_wr_en/cfg_wr_data (reset 465).
//
// The result of a stop bit is registered in the output register.
// Throughput: one sample per cycle, set by the input register feeding the
// frame logic and the output register. s_axis_tready only drops when the
// input register holds a stop bit and the output register is still full
// with m_axis_tready low; samples that finish no frame pass regardless.
// Reset clears the counter, shift word, parity, framing status and both
// valid flags, and loads the default threshold.
module frame_sample_receiver #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,     // level_threshold

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [9:0] line_sample, [15:10] zero
    input  logic        s_axis_tuser,    // [0] frame_start

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,    // [31:0] frame_word, [34:32] message_type,
                                         // [42:35] data_id, [58:43] payload,
                                         // [59] parity_flag, [60] from_master, [63:61] zero
    output logic [1:0]  m_axis_tuser     // [1:0] error_code
);

    // compare width: low SAMPLE_BITS bits, never more than the field holds
    localparam int CMP_BITS = (SAMPLE_BITS < fsr_pkg::LEVEL_W) ? SAMPLE_BITS
                                                                : fsr_pkg::LEVEL_W;

    logic [fsr_pkg::LEVEL_W-1:0] thr_reg;

    logic                        bit_valid;
    fsr_pkg::fsr_bit_t           bit_data;
    logic                        advance;
    logic                        result_valid;
    fsr_pkg::fsr_result_t        result;
    logic [fsr_pkg::INDEX_W-1:0] index_now;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;
    logic [63:0]                 out_data_reg;
    logic [1:0]                  out_code_reg;
    logic [63:0]                 packed_data;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= fsr_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    fsr_input_stage #(
        .CMP_BITS (CMP_BITS)
    ) u_input (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .line_sample     (s_axis_tdata[fsr_pkg::LEVEL_W-1:0]),
        .frame_start     (s_axis_tuser),
        .level_threshold (thr_reg),
        .advance         (advance),
        .bit_valid       (bit_valid),
        .bit_data        (bit_data)
    );

    fsr_frame_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .bit_valid    (bit_valid),
        .bit_data     (bit_data),
        .out_free     (out_free),
        .advance      (advance),
        .result_valid (result_valid),
        .result       (result),
        .index_now    (index_now)
    );

    // field decode off the finished word
    assign packed_data = {3'b000,
                          (result.word[30:28] <= fsr_pkg::MASTER_MAX_TYPE),
                          result.word[31],
                          result.word[15:0],
                          result.word[23:16],
                          result.word[30:28],
                          result.word};

    // output register
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            out_data_reg <= packed_data;
            out_code_reg <= result.code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_code_reg;

    // any error delivers an all-zero frame word
    a_err_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != fsr_pkg::ERR_NONE) |-> (m_axis_tdata[31:0] == '0))
        else $error("error result carries a nonzero frame word");

    // counter never runs past the stop position
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_now <= fsr_pkg::STOP_INDEX)
        else $error("bit counter past stop position");

    // backpressure only while a sample is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> bit_valid)
        else $error("input stalled with empty input register");

    // a new result never overwrites one that was not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && out_valid_reg) |-> m_axis_tready)
        else $error("result overwrote pending output");

endmodule
